// File: design/rrp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the request parser.
// Used by rrp_parser, rrp_result_fifo and resp_request_parser_top; depends on nothing.
package rrp_pkg;

   localparam int LEN_BITS   = 32;
   localparam int INDEX_BITS = 16;
   localparam int NUM_BITS   = 64;

   // Result queue depth, a power of two with room for the two results of one word.
   localparam int RESULT_DEPTH    = 4;
   localparam int RESULT_PTR_BITS = $clog2(RESULT_DEPTH);

   localparam logic [15:0] MAX_PARTS_RESET = 16'd1024;

   // Counts above the part index space are too large whatever max_parts holds.
   localparam logic [NUM_BITS-1:0] INDEX_LIMIT = NUM_BITS'(1) << INDEX_BITS;

   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   // Largest magnitude of a negative number; a positive one may reach one less.
   localparam logic [NUM_BITS+3:0] MAG_NEG = 68'd1 << (NUM_BITS - 1);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ARR_LINE,
      PH_BULK_START,
      PH_BULK_LINE,
      PH_DATA,
      PH_TRAIL_CR,
      PH_TRAIL_LF,
      PH_DONE
   } phase_type;

   typedef enum logic [3:0] {
      ST_OK,
      ST_EMPTY,
      ST_NOT_ARRAY,
      ST_INCOMPLETE_LINE,
      ST_BAD_COUNT,
      ST_EMPTY_COMMAND,
      ST_TOO_LARGE,
      ST_EXPECTED_BULK,
      ST_BAD_LENGTH,
      ST_NULL_BULK,
      ST_INCOMPLETE_BULK,
      ST_MISSING_CRLF,
      ST_EXTRA_DATA
   } status_type;

   typedef enum logic [1:0] {
      KIND_DATA,
      KIND_DONE,
      KIND_STATUS
   } kind_type;

   // Number being collected on a header line; pending holds a held line error.
   typedef struct packed {
      logic [NUM_BITS-1:0] value;
      logic                neg;
      logic                digit;
      logic                ovf;
      status_type          pending;
   } num_type;

   typedef struct packed {
      kind_type              kind;
      logic [7:0]            part_byte;
      logic [INDEX_BITS-1:0] part_index;
      logic [LEN_BITS-1:0]   part_length;
      status_type            status;
   } result_type;

   // One character of a number line. The multiply by ten is two shifts and an add;
   // the sum is kept wide so the overflow test is a single compare.
   function automatic num_type rrp_feed_number(input num_type cur, input logic [7:0] c,
                                               input status_type bad);
      num_type             nx;
      logic [7:0]          d;
      logic [NUM_BITS+3:0] prod;
      logic [NUM_BITS+3:0] lim;
      begin
         nx   = cur;
         d    = c - CHAR_ZERO;
         prod = ({4'b0, cur.value} << 3) + ({4'b0, cur.value} << 1)
                + {{NUM_BITS{1'b0}}, d[3:0]};
         lim  = cur.neg ? MAG_NEG : MAG_NEG - 68'd1;
         if (cur.pending == ST_OK) begin
            if (c == CHAR_MINUS && !cur.digit && !cur.neg) begin
               nx.neg = 1'b1;
            end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
               nx.digit = 1'b1;
               if (!cur.ovf) begin
                  if (prod > lim) begin
                     nx.ovf = 1'b1;
                  end else begin
                     nx.value = prod[NUM_BITS-1:0];
                  end
               end
            end else begin
               nx.pending = bad;
            end
         end
         rrp_feed_number = nx;
      end
   endfunction

endpackage

// File: design/rrp_result_fifo.sv
`timescale 1ns / 1ps
// Four-entry result queue that takes up to two results per cycle and gives one while out_stall is low.
// Depends on rrp_pkg.
module rrp_result_fifo
   import rrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_n,
   input  result_type push_a,
   input  result_type push_b,
   output logic       room,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_word
);

   result_type                 mem_ff [RESULT_DEPTH];
   logic [RESULT_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RESULT_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RESULT_PTR_BITS:0]   count_ff, count_in;
   logic                       pop;
   logic [RESULT_PTR_BITS-1:0] wr_next;

   assign out_valid = (count_ff != '0);
   assign out_word  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;
   // Room for two results, so any item can be taken without looking at the pop.
   assign room      = (count_ff <= (RESULT_PTR_BITS+1)'(RESULT_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + RESULT_PTR_BITS'(1);
   assign wr_ptr_in = wr_ptr_ff + RESULT_PTR_BITS'(push_n);
   assign rd_ptr_in = rd_ptr_ff + RESULT_PTR_BITS'(pop);
   assign count_in  = count_ff + (RESULT_PTR_BITS+1)'(push_n)
                      - (RESULT_PTR_BITS+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_a;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_next] <= push_b;
      end
   end

endmodule

// File: design/rrp_parser.sv
`timescale 1ns / 1ps
// Input word register and the parsing state machine of the request parser.
// Depends on rrp_pkg; its results go to rrp_result_fifo.
module rrp_parser
   import rrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_stall,
   input  logic [7:0]  in_byte,
   input  logic        in_has_byte,
   input  logic        in_end,
   input  logic [15:0] max_parts,
   input  logic        room,
   output logic [1:0]  push_n,
   output result_type  push_a,
   output result_type  push_b
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            byte_ff;
   logic                  has_ff;
   logic                  end_ff;

   phase_type             phase_ff, phase_in;
   num_type               num_ff, num_in;
   logic                  cr_ff, cr_in;
   logic [15:0]           parts_ff, parts_in;
   logic [INDEX_BITS-1:0] cur_ff, cur_in;
   logic [LEN_BITS-1:0]   bytes_ff, bytes_in;
   status_type            err_ff, err_in;

   logic                  go;
   logic                  accept;
   logic [7:0]            line_c;
   status_type            feed_bad;
   num_type               fed;
   status_type            code;
   status_type            end_status;
   logic                  byte_res;
   result_type            byte_word;
   result_type            status_word;

   assign go       = in_valid_ff && room;
   assign in_stall = in_valid_ff && !room;
   assign accept   = in_valid && !in_stall;
   assign in_valid_in = accept ? 1'b1 : (go ? 1'b0 : in_valid_ff);

   // A held carriage return that is not followed by a line feed is fed as a line byte.
   assign line_c   = cr_ff ? CHAR_CR : byte_ff;
   assign feed_bad = (phase_ff == PH_ARR_LINE) ? ST_BAD_COUNT : ST_BAD_LENGTH;
   assign fed      = rrp_feed_number(num_ff, line_c, feed_bad);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= in_byte;
         has_ff  <= in_has_byte;
         end_ff  <= in_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         num_ff   <= '0;
         cr_ff    <= 1'b0;
         parts_ff <= '0;
         cur_ff   <= '0;
         bytes_ff <= '0;
         err_ff   <= ST_OK;
      end else begin
         phase_ff <= phase_in;
         num_ff   <= num_in;
         cr_ff    <= cr_in;
         parts_ff <= parts_in;
         cur_ff   <= cur_in;
         bytes_ff <= bytes_in;
         err_ff   <= err_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      num_in      = num_ff;
      cr_in       = cr_ff;
      parts_in    = parts_ff;
      cur_in      = cur_ff;
      bytes_in    = bytes_ff;
      err_in      = err_ff;
      code        = num_ff.pending;
      end_status  = ST_OK;
      byte_res    = 1'b0;
      byte_word   = '0;
      status_word = '0;
      push_n      = 2'd0;
      push_a      = '0;
      push_b      = '0;

      if (go && has_ff && err_ff == ST_OK) begin
         case (phase_ff)
            PH_IDLE: begin
               if (byte_ff == CHAR_STAR) begin
                  phase_in = PH_ARR_LINE;
                  num_in   = '0;
                  cr_in    = 1'b0;
               end else begin
                  err_in = ST_NOT_ARRAY;
               end
            end
            PH_ARR_LINE, PH_BULK_START, PH_BULK_LINE: begin
               if (cr_ff && byte_ff == CHAR_LF) begin
                  cr_in = 1'b0;
                  if (phase_ff == PH_ARR_LINE) begin
                     if (code == ST_OK && (!num_ff.digit || num_ff.ovf))
                        code = ST_BAD_COUNT;
                     if (code == ST_OK && (num_ff.neg || num_ff.value == '0))
                        code = ST_EMPTY_COMMAND;
                     // The count is bounded by max_parts and by the part index space.
                     if (code == ST_OK && (num_ff.value > NUM_BITS'(max_parts) ||
                                           num_ff.value > INDEX_LIMIT))
                        code = ST_TOO_LARGE;
                     if (code != ST_OK) begin
                        err_in = code;
                     end else begin
                        parts_in = num_ff.value[15:0];
                        cur_in   = '0;
                        phase_in = PH_BULK_START;
                        num_in   = '0;
                     end
                  end else if (phase_ff == PH_BULK_START) begin
                     err_in = ST_EXPECTED_BULK;
                  end else begin
                     if (code == ST_OK && (!num_ff.digit || num_ff.ovf))
                        code = ST_BAD_LENGTH;
                     if (code == ST_OK && num_ff.neg && num_ff.value != '0)
                        code = ST_NULL_BULK;
                     if (code == ST_OK && (num_ff.value >> LEN_BITS) != '0)
                        code = ST_INCOMPLETE_BULK;
                     if (code != ST_OK) begin
                        err_in = code;
                     end else begin
                        bytes_in = num_ff.value[LEN_BITS-1:0];
                        phase_in = (num_ff.value == '0) ? PH_TRAIL_CR : PH_DATA;
                     end
                  end
               end else if (cr_ff) begin
                  // The stray carriage return always leaves a line error pending,
                  // so the byte after it has no further effect on the number.
                  if (phase_ff == PH_BULK_START) begin
                     phase_in       = PH_BULK_LINE;
                     num_in.pending = ST_EXPECTED_BULK;
                  end else begin
                     num_in = fed;
                  end
                  cr_in = (byte_ff == CHAR_CR);
               end else if (byte_ff == CHAR_CR) begin
                  cr_in = 1'b1;
               end else if (phase_ff == PH_BULK_START) begin
                  phase_in = PH_BULK_LINE;
                  if (byte_ff != CHAR_DOLLAR) begin
                     num_in.pending = ST_EXPECTED_BULK;
                  end
               end else begin
                  num_in = fed;
               end
            end
            PH_DATA: begin
               byte_res             = 1'b1;
               byte_word.kind       = KIND_DATA;
               byte_word.part_byte  = byte_ff;
               byte_word.part_index = cur_ff;
               bytes_in             = bytes_ff - 1'b1;
               if (bytes_ff == LEN_BITS'(1)) begin
                  phase_in = PH_TRAIL_CR;
               end
            end
            PH_TRAIL_CR: begin
               num_in.pending = (byte_ff == CHAR_CR) ? ST_OK : ST_MISSING_CRLF;
               phase_in       = PH_TRAIL_LF;
            end
            PH_TRAIL_LF: begin
               if (num_ff.pending != ST_OK || byte_ff != CHAR_LF) begin
                  err_in = ST_MISSING_CRLF;
               end else begin
                  byte_res               = 1'b1;
                  byte_word.kind         = KIND_DONE;
                  byte_word.part_index   = cur_ff;
                  byte_word.part_length  = num_ff.value[LEN_BITS-1:0];
                  parts_in               = parts_ff - 1'b1;
                  cur_in                 = cur_ff + 1'b1;
                  num_in                 = '0;
                  cr_in                  = 1'b0;
                  phase_in = (parts_ff != 16'd1) ? PH_BULK_START : PH_DONE;
               end
            end
            default: begin
               err_in = ST_EXTRA_DATA;
            end
         endcase
      end

      if (err_in != ST_OK) begin
         end_status = err_in;
      end else begin
         case (phase_in)
            PH_IDLE:                                end_status = ST_EMPTY;
            PH_ARR_LINE, PH_BULK_START, PH_BULK_LINE: end_status = ST_INCOMPLETE_LINE;
            PH_DONE:                                end_status = ST_OK;
            default:                                end_status = ST_INCOMPLETE_BULK;
         endcase
      end
      status_word.kind   = KIND_STATUS;
      status_word.status = end_status;

      if (byte_res) begin
         push_a = byte_word;
         push_n = 2'd1;
      end

      if (go && end_ff) begin
         if (byte_res) begin
            push_b = status_word;
            push_n = 2'd2;
         end else begin
            push_a = status_word;
            push_n = 2'd1;
         end
         phase_in = PH_IDLE;
         num_in   = '0;
         cr_in    = 1'b0;
         parts_in = '0;
         cur_in   = '0;
         bytes_in = '0;
         err_in   = ST_OK;
      end
   end

endmodule

// File: design/resp_request_parser_top.sv
`timescale 1ns / 1ps
// Top level of the streaming request parser: configuration register, parser, result queue.
// Depends on rrp_pkg, rrp_parser and rrp_result_fifo.
//
// The block checks a request framed as "*count CRLF" and then count parts of the form
// "$len CRLF data CRLF", one request byte per word on the req_ channel. A word may carry
// a byte (req_has_byte), mark the end of the request (req_end_of_request), or both.
// On the rsp_ channel it gives, per part, every data byte with its part index, then a
// completion word with the part's length once the closing CRLF has been seen; when a
// request ends it gives exactly one status word. After a request end the parser is
// back in its reset state and the next request may follow in the next word.
// A word is taken when its valid is high and its stall is low, on both channels.
// Each request word is registered in the input register, then parsed once the result
// queue has room, and its results are written into that queue, which drives rsp_.
// The block takes one request word every cycle while the queue has room; a word
// that both finishes a part and ends the request yields two results, which drain
// through a four-entry result queue at one per cycle while rsp_ is not stalled.
// The request side is stalled only while that queue holds more than two results,
// which happens when the receiver stalls rsp_ or many such two-result words arrive.
// The csr_ channel writes max_parts (reset value 1024); csr_ready is always high and
// it should be written only while no request is in flight.
// Synchronous reset empties the input register and the queue and restarts parsing.
module resp_request_parser_top
   import rrp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_has_byte,
   input  logic                  req_end_of_request,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_part_byte,
   output logic [INDEX_BITS-1:0] rsp_part_index,
   output logic [LEN_BITS-1:0]   rsp_part_length,
   output logic [3:0]            rsp_status,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_max_parts
);

   logic [15:0] max_parts_ff, max_parts_in;
   logic        room;
   logic [1:0]  push_n;
   result_type  push_a;
   result_type  push_b;
   result_type  out_word;

   // The register always takes a write in the cycle it is offered.
   assign csr_ready    = 1'b1;
   assign max_parts_in = (csr_valid && csr_ready) ? csr_max_parts : max_parts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_parts_ff <= MAX_PARTS_RESET;
      end else begin
         max_parts_ff <= max_parts_in;
      end
   end

   rrp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_stall    (req_stall),
      .in_byte     (req_data_byte),
      .in_has_byte (req_has_byte),
      .in_end      (req_end_of_request),
      .max_parts   (max_parts_ff),
      .room        (room),
      .push_n      (push_n),
      .push_a      (push_a),
      .push_b      (push_b)
   );

   rrp_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_a    (push_a),
      .push_b    (push_b),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (out_word)
   );

   // Fields that do not belong to a result's kind are zero.
   assign rsp_kind        = out_word.kind;
   assign rsp_part_byte   = out_word.part_byte;
   assign rsp_part_index  = out_word.part_index;
   assign rsp_part_length = out_word.part_length;
   assign rsp_status      = out_word.status;

endmodule

// File: verif/rrp_parse_checker.sv
`timescale 1ns / 1ps
// Checker for resp_request_parser_top: watches the req_, rsp_ and csr_ channels, predicts
// every result word of the request parser and compares it with what the block sends.
// Depends on rrp_pkg for the result layout and the phase, status and kind codes.
module rrp_parse_checker
   import rrp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_has_byte,
   input  logic                  req_end_of_request,

   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [1:0]            rsp_kind,
   input  logic [7:0]            rsp_part_byte,
   input  logic [INDEX_BITS-1:0] rsp_part_index,
   input  logic [LEN_BITS-1:0]   rsp_part_length,
   input  logic [3:0]            rsp_status,

   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [15:0]           csr_max_parts,

   output int                    fail_count,
   output int                    pending_count,
   output int                    results_checked,
   output int                    status_words_checked
);

   localparam logic [63:0] NEG_CEILING    = 64'h8000_0000_0000_0000;
   localparam logic [63:0] POS_CEILING    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] LENGTH_CEILING = (64'd1 << LEN_BITS) - 64'd1;
   localparam logic [63:0] INDEX_SPAN     = 64'd1 << INDEX_BITS;

   // Predicted parser state and the register copy.
   logic [15:0]           limit_parts = MAX_PARTS_RESET;
   phase_type             ph;
   logic [63:0]           num_mag;
   logic                  num_neg;
   logic                  num_digit;
   logic                  num_ovf;
   status_type            line_err;
   logic                  cr_seen;
   logic [15:0]           parts_left;
   logic [INDEX_BITS-1:0] part_num;
   logic [LEN_BITS-1:0]   bytes_left;
   status_type            err;

   result_type expected_results[$];
   int mismatches = 0;
   int compared   = 0;
   int statuses   = 0;

   function automatic void expect_word(input kind_type k, input logic [7:0] b,
                                       input logic [INDEX_BITS-1:0] idx,
                                       input logic [LEN_BITS-1:0] len, input status_type st);
      result_type r;
      r.kind        = k;
      r.part_byte   = b;
      r.part_index  = idx;
      r.part_length = len;
      r.status      = st;
      expected_results.insert(expected_results.size(), r);
   endfunction

   function automatic void clear_number();
      num_mag   = '0;
      num_neg   = 1'b0;
      num_digit = 1'b0;
      num_ovf   = 1'b0;
      line_err  = ST_OK;
      cr_seen   = 1'b0;
   endfunction

   function automatic void clear_parse();
      ph = PH_IDLE;
      clear_number();
      parts_left = '0;
      part_num   = '0;
      bytes_left = '0;
      err        = ST_OK;
   endfunction

   function automatic void number_char(input logic [7:0] c, input status_type bad);
      logic [63:0] digit;
      logic [63:0] ceiling;
      if (line_err != ST_OK) return;
      if (c == CHAR_MINUS && !num_digit && !num_neg) begin
         num_neg = 1'b1;
         return;
      end
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         digit     = {56'd0, c - CHAR_ZERO};
         ceiling   = num_neg ? NEG_CEILING : POS_CEILING;
         num_digit = 1'b1;
         if (!num_ovf) begin
            if (num_mag > (ceiling - digit) / 64'd10) begin
               num_ovf = 1'b1;
            end else begin
               num_mag = num_mag * 64'd10 + digit;
            end
         end
         return;
      end
      line_err = bad;
   endfunction

   function automatic void line_char(input logic [7:0] c);
      if (ph == PH_ARR_LINE) begin
         number_char(c, ST_BAD_COUNT);
      end else if (ph == PH_BULK_START) begin
         ph = PH_BULK_LINE;
         if (c != CHAR_DOLLAR) line_err = ST_EXPECTED_BULK;
      end else begin
         number_char(c, ST_BAD_LENGTH);
      end
   endfunction

   function automatic void close_line();
      status_type  code;
      logic [63:0] count_ceiling;
      code = line_err;
      if (ph == PH_ARR_LINE) begin
         count_ceiling = ({48'd0, limit_parts} < INDEX_SPAN) ? {48'd0, limit_parts} : INDEX_SPAN;
         if (code == ST_OK && (!num_digit || num_ovf)) code = ST_BAD_COUNT;
         if (code == ST_OK && (num_neg || num_mag == 0)) code = ST_EMPTY_COMMAND;
         if (code == ST_OK && num_mag > count_ceiling) code = ST_TOO_LARGE;
         if (code != ST_OK) begin
            err = code;
            return;
         end
         parts_left = num_mag[15:0];
         part_num   = '0;
         ph         = PH_BULK_START;
         clear_number();
      end else if (ph == PH_BULK_START) begin
         err = ST_EXPECTED_BULK;
      end else begin
         if (code == ST_OK && (!num_digit || num_ovf)) code = ST_BAD_LENGTH;
         if (code == ST_OK && num_neg && num_mag != 0) code = ST_NULL_BULK;
         if (code == ST_OK && num_mag > LENGTH_CEILING) code = ST_INCOMPLETE_BULK;
         if (code != ST_OK) begin
            err = code;
            return;
         end
         cr_seen    = 1'b0;
         bytes_left = num_mag[LEN_BITS-1:0];
         if (num_mag != 0) begin
            ph = PH_DATA;
         end else begin
            ph = PH_TRAIL_CR;
         end
      end
   endfunction

   function automatic void request_byte(input logic [7:0] c);
      if (err != ST_OK) return;
      case (ph)
         PH_IDLE: begin
            if (c == CHAR_STAR) begin
               ph = PH_ARR_LINE;
               clear_number();
            end else begin
               err = ST_NOT_ARRAY;
            end
         end
         PH_ARR_LINE, PH_BULK_START, PH_BULK_LINE: begin
            // A CR only closes the line when LF follows; otherwise it is a line byte.
            if (cr_seen) begin
               cr_seen = 1'b0;
               if (c == CHAR_LF) begin
                  close_line();
                  return;
               end
               line_char(CHAR_CR);
            end
            if (c == CHAR_CR) begin
               cr_seen = 1'b1;
            end else begin
               line_char(c);
            end
         end
         PH_DATA: begin
            expect_word(KIND_DATA, c, part_num, '0, ST_OK);
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == 0) ph = PH_TRAIL_CR;
         end
         PH_TRAIL_CR: begin
            if (c == CHAR_CR) begin
               line_err = ST_OK;
            end else begin
               line_err = ST_MISSING_CRLF;
            end
            ph = PH_TRAIL_LF;
         end
         PH_TRAIL_LF: begin
            if (line_err != ST_OK || c != CHAR_LF) begin
               err = ST_MISSING_CRLF;
            end else begin
               expect_word(KIND_DONE, 8'd0, part_num, num_mag[LEN_BITS-1:0], ST_OK);
               parts_left = parts_left - 1'b1;
               part_num   = part_num + 1'b1;
               clear_number();
               if (parts_left != 0) begin
                  ph = PH_BULK_START;
               end else begin
                  ph = PH_DONE;
               end
            end
         end
         default: begin
            err = ST_EXTRA_DATA;
         end
      endcase
   endfunction

   function automatic void predict_word(input logic [7:0] b, input logic hb, input logic eor);
      status_type st;
      if (hb) request_byte(b);
      if (!eor) return;
      if (err != ST_OK) begin
         st = err;
      end else begin
         case (ph)
            PH_IDLE:                                st = ST_EMPTY;
            PH_ARR_LINE, PH_BULK_START, PH_BULK_LINE: st = ST_INCOMPLETE_LINE;
            PH_DONE:                                st = ST_OK;
            default:                                st = ST_INCOMPLETE_BULK;
         endcase
      end
      expect_word(KIND_STATUS, 8'd0, '0, '0, st);
      clear_parse();
   endfunction

   function automatic void check_result();
      result_type want;
      if (expected_results.size() == 0) begin
         $error("result word with none expected: kind %0d byte %0d index %0d %s %0d %s %0d",
                rsp_kind, rsp_part_byte, rsp_part_index, "length", rsp_part_length,
                "status", rsp_status);
         mismatches++;
         return;
      end
      want = expected_results.pop_front();
      compared++;
      if (want.kind == KIND_STATUS) statuses++;
      if (rsp_kind !== want.kind) begin
         $error("kind mismatch: expected %0d, got %0d", want.kind, rsp_kind);
         mismatches++;
      end
      if (rsp_part_byte !== want.part_byte) begin
         $error("part_byte mismatch: expected %0d, got %0d", want.part_byte, rsp_part_byte);
         mismatches++;
      end
      if (rsp_part_index !== want.part_index) begin
         $error("part_index mismatch: expected %0d, got %0d", want.part_index, rsp_part_index);
         mismatches++;
      end
      if (rsp_part_length !== want.part_length) begin
         $error("part_length mismatch: expected %0d, got %0d", want.part_length,
                rsp_part_length);
         mismatches++;
      end
      if (rsp_status !== want.status) begin
         $error("status mismatch: expected %0d, got %0d", want.status, rsp_status);
         mismatches++;
      end
   endfunction

   // Results leave the block only after their word has passed the input register and the
   // result queue, so comparing before predicting at the same edge never misses an expectation.
   always @(posedge clock) begin
      if (reset) begin
         limit_parts = MAX_PARTS_RESET;
         clear_parse();
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) limit_parts = csr_max_parts;
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) begin
            predict_word(req_data_byte, req_has_byte, req_end_of_request);
         end
      end
      fail_count           <= mismatches;
      pending_count        <= expected_results.size();
      results_checked      <= compared;
      status_words_checked <= statuses;
   end

endmodule

// File: verif/resp_request_parser_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for resp_request_parser_top: drives request words and max_parts writes,
// stalls the result side at random and gives the verdict.
// Depends on rrp_pkg, the block itself and rrp_parse_checker.
module resp_request_parser_top_tb;
   import rrp_pkg::*;

   // About 1200 random request words, spread over the max_parts settings below.
   localparam int SETTING_COUNT = 6;
   localparam int RANDOM_WORDS  = 1200;
   localparam int CYCLE_LIMIT   = 1000000;
   // Settle time after the last expectation is met; it covers the input register and the
   // result queue before the block is taken as idle.
   localparam int SETTLE_CYCLES = 8;

   // Every block input starts at a known value.
   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  req_valid          = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_data_byte      = 8'h00;
   logic                  req_has_byte       = 1'b0;
   logic                  req_end_of_request = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall          = 1'b0;
   logic [1:0]            rsp_kind;
   logic [7:0]            rsp_part_byte;
   logic [INDEX_BITS-1:0] rsp_part_index;
   logic [LEN_BITS-1:0]   rsp_part_length;
   logic [3:0]            rsp_status;
   logic                  csr_valid          = 1'b0;
   logic                  csr_ready;
   logic [15:0]           csr_max_parts      = MAX_PARTS_RESET;

   int fail_count;
   int pending_count;
   int results_checked;
   int status_words_checked;

   // Bytes of the request being built, the register value the block holds now, and the
   // number of words that carried a byte or an end.
   logic [7:0]  req_text[$];
   logic [15:0] cur_max_parts = MAX_PARTS_RESET;
   int          words_sent    = 0;
   int          cycle_count   = 0;
   // While set, neither side idles, so back-to-back traffic is covered too.
   bit          calm_run      = 1'b0;

   resp_request_parser_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_has_byte       (req_has_byte),
      .req_end_of_request (req_end_of_request),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_part_byte      (rsp_part_byte),
      .rsp_part_index     (rsp_part_index),
      .rsp_part_length    (rsp_part_length),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_max_parts      (csr_max_parts)
   );

   rrp_parse_checker parse_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_has_byte         (req_has_byte),
      .req_end_of_request   (req_end_of_request),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kind             (rsp_kind),
      .rsp_part_byte        (rsp_part_byte),
      .rsp_part_index       (rsp_part_index),
      .rsp_part_length      (rsp_part_length),
      .rsp_status           (rsp_status),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_parts        (csr_max_parts),
      .fail_count           (fail_count),
      .pending_count        (pending_count),
      .results_checked      (results_checked),
      .status_words_checked (status_words_checked)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // The run is cut off here if the block hangs or stops answering.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // The receiver: short open stretches, then mostly brief stalls and now and then a
   // long one, so that the result queue fills and the block stalls the request side.
   initial begin
      int hold;
      forever begin
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         if (!calm_run) begin
            if ($urandom_range(0, 9) == 0) begin
               hold = $urandom_range(10, 50);
            end else begin
               hold = $urandom_range(1, 3);
            end
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
      end
   end

   // Idle cycles before a request word: mostly none, some short, a few long.
   function automatic int pick_gap();
      int r;
      if (calm_run) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offers one word and returns at the edge where it is taken. Valid stays high for
   // the next word, so it is only lowered when a gap follows.
   task automatic send_word(input logic [7:0] b, input logic hb, input logic eor);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= b;
      req_has_byte       <= hb;
      req_end_of_request <= eor;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (hb || eor) words_sent++;
   endtask

   // Sends the bytes in req_text, with the end either on the last byte or in a word of
   // its own. Words with neither byte nor end are slipped in now and then; the block
   // must ignore them.
   task automatic deliver_request(input bit attach);
      int last;
      last = req_text.size() - 1;
      if (last < 0) attach = 1'b0;
      for (int i = 0; i <= last; i++) begin
         if ($urandom_range(0, 11) == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_word(req_text[i], 1'b1, attach && i == last);
      end
      if (!attach) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // Waits until the checker holds no expectation, then lets the block settle, since
   // header bytes give no result and may still be in the pipeline.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_parts(input logic [15:0] value);
      csr_valid     <= 1'b1;
      csr_max_parts <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid     <= 1'b0;
      cur_max_parts = value;
   endtask

   // The extremes of the register come first, the reset value comes back later.
   function automatic logic [15:0] planned_max_parts(input int idx);
      case (idx)
         0:       return 16'd1;
         1:       return 16'd65535;
         2:       return 16'd2;
         3:       return MAX_PARTS_RESET;
         4:       return 16'd3;
         default: return 16'd17;
      endcase
   endfunction

   // Appends one byte to the request being built.
   function automatic void add_byte(input logic [7:0] b);
      req_text.insert(req_text.size(), b);
   endfunction

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   // Bytes that steer the parser: line ends, markers, sign and digit bounds.
   function automatic logic [7:0] special_byte();
      case ($urandom_range(0, 7))
         0:       return CHAR_CR;
         1:       return CHAR_LF;
         2:       return CHAR_DOLLAR;
         3:       return CHAR_STAR;
         4:       return CHAR_MINUS;
         5:       return CHAR_ZERO;
         6:       return CHAR_NINE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Number tokens at the edges: empty, lone or double sign, negative zero, leading
   // zeros, stray characters, the signed 64-bit bounds and the 32-bit length bound.
   function automatic string odd_number();
      case ($urandom_range(0, 17))
         0:       return "";
         1:       return "-";
         2:       return "-0";
         3:       return "0";
         4:       return "007";
         5:       return "--1";
         6:       return "1-";
         7:       return "-1";
         8:       return "12a";
         9:       return "9223372036854775807";
         10:      return "9223372036854775808";
         11:      return "-9223372036854775808";
         12:      return "-9223372036854775809";
         13:      return "99999999999999999999";
         14:      return "4294967295";
         15:      return "4294967296";
         16:      return "65535";
         default: return "65536";
      endcase
   endfunction

   // Part lengths: mostly a few bytes, some empty parts, a few longer ones.
   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 0;
      if (r < 85) return $urandom_range(1, 8);
      return $urandom_range(9, 40);
   endfunction

   function automatic void build_wellformed();
      int most;
      int parts;
      int len;
      most  = (cur_max_parts < 16'd4) ? int'(cur_max_parts) : 4;
      parts = $urandom_range(1, most);
      put_text($sformatf("*%0d\r\n", parts));
      repeat (parts) begin
         len = pick_length();
         put_text($sformatf("$%0d\r\n", len));
         repeat (len) add_byte(8'($urandom_range(0, 255)));
         put_text("\r\n");
      end
   endfunction

   // Breaks a well-formed request: cut it short, overwrite or insert a steering byte,
   // or add bytes after the last part.
   function automatic void mangle_request();
      int pos;
      pos = $urandom_range(0, req_text.size() - 1);
      case ($urandom_range(0, 3))
         0: begin
            while (req_text.size() > pos) req_text.delete(req_text.size() - 1);
         end
         1: req_text[pos] = special_byte();
         2: req_text.insert(pos, special_byte());
         default: begin
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
         end
      endcase
   endfunction

   // Requests aimed at one header or framing rule each.
   function automatic void build_odd_request();
      case ($urandom_range(0, 5))
         0: begin
            put_text({"*", odd_number(), "\r\n"});
            put_text("$1\r\nZ\r\n");
         end
         1: begin
            put_text({"*1\r\n$", odd_number(), "\r\n"});
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
            put_text("\r\n");
         end
         2: begin
            // A count right at the register value, or one past it.
            put_text($sformatf("*%0d\r\n$1\r\nZ\r\n",
                               int'(cur_max_parts) + $urandom_range(0, 1)));
         end
         3: begin
            // A CR inside a header line that is not followed by LF.
            if ($urandom_range(0, 1) == 0) begin
               put_text("*1\r2\r\n");
            end else begin
               put_text("*1\r\n$1\r2\r\nZ\r\n");
            end
         end
         4: begin
            // A part header without its marker, or an empty line where it belongs.
            if ($urandom_range(0, 1) == 0) begin
               put_text("*1\r\n:1\r\nZ\r\n");
            end else begin
               put_text("*2\r\n\r\n");
            end
         end
         default: begin
            // Wrong bytes where the closing CRLF of the data belongs; sometimes the
            // request ends right after the first of them.
            put_text("*1\r\n$2\r\nab");
            add_byte(($urandom_range(0, 1) == 0) ? CHAR_CR : 8'h78);
            if ($urandom_range(0, 2) != 0) begin
               add_byte(($urandom_range(0, 1) == 0) ? CHAR_LF : 8'h79);
            end
         end
      endcase
   endfunction

   // Mostly well-formed requests with random content, since only those get past the
   // header; the rest are broken requests, targeted header cases and plain noise.
   task automatic random_request();
      int shape;
      req_text.delete();
      calm_run = ($urandom_range(0, 7) == 0);
      shape    = $urandom_range(0, 99);
      if (shape < 62) begin
         build_wellformed();
      end else if (shape < 78) begin
         build_wellformed();
         mangle_request();
      end else if (shape < 92) begin
         build_odd_request();
      end else begin
         repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
      end
      deliver_request($urandom_range(0, 1));
   endtask

   initial begin
      int phase_goal;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset value of max_parts.
      calm_run = 1'b0;
      // An end with no byte before it; the data byte must be ignored.
      req_text.delete();
      deliver_request(1'b0);
      // A first byte that does not open an array.
      req_text.delete();
      add_byte(8'hFF);
      deliver_request(1'b1);
      // The request ends on the array marker.
      req_text.delete();
      put_text("*");
      deliver_request(1'b1);
      // Negative zero as the count.
      req_text.delete();
      put_text("*-0\r\n");
      deliver_request(1'b1);
      // An empty part, with the end on its last byte: completion and status together.
      req_text.delete();
      put_text("*1\r\n$0\r\n\r\n");
      deliver_request(1'b1);
      wait_quiet();

      // Random requests under each setting; the register is written only while idle.
      for (int setting = 0; setting < SETTING_COUNT; setting++) begin
         write_max_parts(planned_max_parts(setting));
         phase_goal = words_sent + RANDOM_WORDS / SETTING_COUNT;
         while (words_sent < phase_goal) random_request();
         calm_run = 1'b0;
         wait_quiet();
      end

      $display("Run covered %0d request words under %0d max_parts settings from 1 to 65535.",
               words_sent, SETTING_COUNT);
      $display("%0d result words were compared, %0d of them request status words.",
               results_checked, status_words_checked);
      if (fail_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
